// ----- hw/rtl/lcabl_pkg.sv -----
`default_nettype none

package lcabl_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int LOG_LEVELS = 10;
    localparam int NODE_W     = 11;
    localparam int DEPTH_W    = 10;
    localparam int LVL_W      = 4;
    localparam int TBL_ADDR_W = LVL_W + NODE_W;
    localparam int TBL_DEPTH  = LOG_LEVELS * (2 ** NODE_W);
    localparam int DEP_DEPTH  = MAX_NODES + 1;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

endpackage

`default_nettype wire

// ----- hw/rtl/lcabl_ram.sv -----
`default_nettype none

module lcabl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lca_binary_lifting.sv -----
// channel   | dir | signals                      | content
// s_axis    | in  | tvalid tready tdata tuser tlast | parent load or ancestor query
// m_axis    | out | tvalid tready tdata tuser    | ancestor answer, one per query
// cfg       | in  | cfg_we cfg_wdata             | node_count
// A load is taken while idle; the last load (tlast) with a nonzero node_count starts
// a build of the ancestor table and the depth table.
// A query runs a binary search over depth; its lift steps are paced
// by the single read port of the ancestor table, one table read per lift step,
// and the answer waits in its output state while the output stalls.
// One transaction at a time; tready is low during build and query work.
// Reset clears control state and the output valid; the memories are not cleared.
`default_nettype none

module lca_binary_lifting (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [lcabl_pkg::NODE_W-1:0]    cfg_wdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // child_node[10:0], parent_node[21:11], query_a[32:22], query_b[43:33], zero[47:44]
    input  wire logic [lcabl_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // func[0]
    input  wire logic                            s_axis_tuser,
    input  wire logic                            s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // ancestor[10:0], zero[15:11]
    output logic [lcabl_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // found[0]
    output logic                                 m_axis_tuser
);

    import lcabl_pkg::*;

    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] S_IDLE   = 5'd0;
    localparam logic [ST_W-1:0] S_B0_RD  = 5'd1;
    localparam logic [ST_W-1:0] S_B0_WR  = 5'd2;
    localparam logic [ST_W-1:0] S_BL_RD  = 5'd3;
    localparam logic [ST_W-1:0] S_BL_MID = 5'd4;
    localparam logic [ST_W-1:0] S_BL_WR  = 5'd5;
    localparam logic [ST_W-1:0] S_BD_RD  = 5'd6;
    localparam logic [ST_W-1:0] S_BD_CHK = 5'd7;
    localparam logic [ST_W-1:0] S_Q_RA   = 5'd8;
    localparam logic [ST_W-1:0] S_Q_RB   = 5'd9;
    localparam logic [ST_W-1:0] S_Q_DIFF = 5'd10;
    localparam logic [ST_W-1:0] S_L_STEP = 5'd11;
    localparam logic [ST_W-1:0] S_L_WAIT = 5'd12;
    localparam logic [ST_W-1:0] S_Q_ADJ  = 5'd13;
    localparam logic [ST_W-1:0] S_Q_CMP  = 5'd14;
    localparam logic [ST_W-1:0] S_BS     = 5'd15;
    localparam logic [ST_W-1:0] S_BS_A   = 5'd16;
    localparam logic [ST_W-1:0] S_BS_B   = 5'd17;
    localparam logic [ST_W-1:0] S_OUT    = 5'd18;

    localparam logic [LVL_W-1:0]  LVL_TOP  = LVL_W'(LOG_LEVELS - 1);
    localparam logic [LVL_W-1:0]  LVL_END  = LVL_W'(LOG_LEVELS);
    localparam logic [NODE_W-1:0] NODE_MAX = NODE_W'(MAX_NODES);
    localparam logic [NODE_W-1:0] NODE_ONE = NODE_W'(1);

    logic [ST_W-1:0]    state_reg, state_next;
    logic [NODE_W-1:0]  count_reg;
    logic [NODE_W-1:0]  node_reg, node_next;
    logic [LVL_W-1:0]   lvl_reg, lvl_next;
    logic [NODE_W-1:0]  x_reg, x_next;
    logic [DEPTH_W-1:0] d_reg, d_next;
    logic [NODE_W-1:0]  a_reg, a_next;
    logic [NODE_W-1:0]  b_reg, b_next;
    logic [DEPTH_W-1:0] da_reg, da_next;
    logic               side_reg, side_next;
    logic [NODE_W-1:0]  ln_reg, ln_next;
    logic [DEPTH_W-1:0] ls_reg, ls_next;
    logic [LVL_W-1:0]   li_reg, li_next;
    logic [ST_W-1:0]    lret_reg, lret_next;
    logic [NODE_W-1:0]  lo_reg, lo_next;
    logic [DEPTH_W-1:0] hi_reg, hi_next;
    logic [DEPTH_W-1:0] mid_reg, mid_next;
    logic [NODE_W-1:0]  pa_reg, pa_next;
    logic [NODE_W-1:0]  best_reg, best_next;
    logic [NODE_W-1:0]  res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    logic [NODE_W-1:0]  out_anc_reg, out_anc_next;

    logic [NODE_W-1:0]     cnt;
    logic [NODE_W-1:0]     in_child, in_parent, in_qa, in_qb;
    logic                  accept;
    logic [DEPTH_W-1:0]    d_acc;
    logic [NODE_W-1:0]     mid_sum;

    logic                  t_we;
    logic [TBL_ADDR_W-1:0] t_waddr, t_raddr;
    logic [NODE_W-1:0]     t_wdata, t_rdata;
    logic                  dp_we;
    logic [NODE_W-1:0]     dp_waddr, dp_raddr;
    logic [DEPTH_W-1:0]    dp_wdata, dp_rdata;

    assign cnt       = (count_reg > NODE_MAX) ? NODE_MAX : count_reg;
    assign in_child  = s_axis_tdata[10:0];
    assign in_parent = s_axis_tdata[21:11];
    assign in_qa     = s_axis_tdata[32:22];
    assign in_qb     = s_axis_tdata[43:33];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign mid_sum   = lo_reg + NODE_W'(hi_reg);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - NODE_W){1'b0}}, out_anc_reg};
    assign m_axis_tuser  = (out_anc_reg != '0);

    always_comb
    begin
        d_acc = d_reg;
        if (t_rdata != '0)
        begin
            d_acc = d_reg | (DEPTH_W'(1) << lvl_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        node_next      = node_reg;
        lvl_next       = lvl_reg;
        x_next         = x_reg;
        d_next         = d_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        da_next        = da_reg;
        side_next      = side_reg;
        ln_next        = ln_reg;
        ls_next        = ls_reg;
        li_next        = li_reg;
        lret_next      = lret_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        pa_next        = pa_reg;
        best_next      = best_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_anc_next   = out_anc_reg;
        t_we           = 1'b0;
        t_waddr        = '0;
        t_wdata        = '0;
        t_raddr        = '0;
        dp_we          = 1'b0;
        dp_waddr       = node_reg;
        dp_wdata       = d_acc;
        dp_raddr       = a_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tuser == FUNC_LOAD)
                    begin
                        if (in_child >= NODE_W'(2) && in_child <= cnt &&
                            in_parent >= NODE_ONE && in_parent <= cnt)
                        begin
                            t_we    = 1'b1;
                            t_waddr = {LVL_W'(0), in_child};
                            t_wdata = in_parent;
                        end
                        if (s_axis_tlast && cnt != '0)
                        begin
                            node_next  = NODE_ONE;
                            state_next = S_B0_RD;
                        end
                    end
                    else
                    begin
                        a_next     = in_qa;
                        b_next     = in_qb;
                        state_next = S_Q_RA;
                    end
                end
            end
            S_B0_RD:
            begin
                t_raddr    = {LVL_W'(0), node_reg};
                state_next = S_B0_WR;
            end
            S_B0_WR:
            begin
                if (node_reg == NODE_ONE || t_rdata > cnt)
                begin
                    t_we    = 1'b1;
                    t_waddr = {LVL_W'(0), node_reg};
                    t_wdata = '0;
                end
                if (node_reg == cnt)
                begin
                    node_next  = NODE_ONE;
                    lvl_next   = LVL_W'(1);
                    state_next = (LOG_LEVELS > 1) ? S_BL_RD : S_BD_RD;
                    if (LOG_LEVELS == 1)
                    begin
                        lvl_next = '0;
                        x_next   = NODE_ONE;
                        d_next   = '0;
                    end
                end
                else
                begin
                    node_next  = node_reg + NODE_ONE;
                    state_next = S_B0_RD;
                end
            end
            S_BL_RD:
            begin
                t_raddr    = {lvl_reg - LVL_W'(1), node_reg};
                state_next = S_BL_MID;
            end
            S_BL_MID, S_BL_WR:
            begin
                t_raddr = {lvl_reg - LVL_W'(1), t_rdata};
                if (state_reg == S_BL_MID && t_rdata != '0)
                begin
                    state_next = S_BL_WR;
                end
                else
                begin
                    t_we    = 1'b1;
                    t_waddr = {lvl_reg, node_reg};
                    t_wdata = (state_reg == S_BL_WR) ? t_rdata : '0;
                    if (node_reg == cnt)
                    begin
                        node_next = NODE_ONE;
                        if (lvl_reg == LVL_TOP)
                        begin
                            x_next     = NODE_ONE;
                            d_next     = '0;
                            state_next = S_BD_RD;
                        end
                        else
                        begin
                            lvl_next   = lvl_reg + LVL_W'(1);
                            state_next = S_BL_RD;
                        end
                    end
                    else
                    begin
                        node_next  = node_reg + NODE_ONE;
                        state_next = S_BL_RD;
                    end
                end
            end
            S_BD_RD:
            begin
                t_raddr    = {lvl_reg, x_reg};
                state_next = S_BD_CHK;
            end
            S_BD_CHK:
            begin
                if (t_rdata != '0)
                begin
                    x_next = t_rdata;
                end
                d_next = d_acc;
                if (lvl_reg == '0)
                begin
                    dp_we = 1'b1;
                    lvl_next = LVL_TOP;
                    d_next   = '0;
                    x_next   = node_reg + NODE_ONE;
                    if (node_reg == cnt)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        node_next  = node_reg + NODE_ONE;
                        state_next = S_BD_RD;
                    end
                end
                else
                begin
                    lvl_next   = lvl_reg - LVL_W'(1);
                    state_next = S_BD_RD;
                end
            end
            S_Q_RA:
            begin
                dp_raddr = a_reg;
                if (a_reg == '0 || a_reg > cnt || b_reg == '0 || b_reg > cnt)
                begin
                    res_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_Q_RB;
                end
            end
            S_Q_RB:
            begin
                dp_raddr   = b_reg;
                da_next    = dp_rdata;
                state_next = S_Q_DIFF;
            end
            S_Q_DIFF:
            begin
                hi_next = (da_reg < dp_rdata) ? da_reg : dp_rdata;
                li_next = '0;
                lret_next = S_Q_ADJ;
                if (da_reg < dp_rdata)
                begin
                    side_next  = 1'b1;
                    ln_next    = b_reg;
                    ls_next    = dp_rdata - da_reg;
                    state_next = S_L_STEP;
                end
                else if (da_reg > dp_rdata)
                begin
                    side_next  = 1'b0;
                    ln_next    = a_reg;
                    ls_next    = da_reg - dp_rdata;
                    state_next = S_L_STEP;
                end
                else
                begin
                    state_next = S_Q_CMP;
                end
            end
            S_L_STEP:
            begin
                t_raddr = {li_reg, ln_reg};
                if (li_reg == LVL_END || ln_reg == '0)
                begin
                    state_next = lret_reg;
                end
                else if (ls_reg[li_reg[LVL_W-1:0]])
                begin
                    state_next = S_L_WAIT;
                end
                else
                begin
                    li_next = li_reg + LVL_W'(1);
                end
            end
            S_L_WAIT:
            begin
                ln_next    = t_rdata;
                li_next    = li_reg + LVL_W'(1);
                state_next = S_L_STEP;
            end
            S_Q_ADJ:
            begin
                if (side_reg)
                begin
                    b_next = ln_reg;
                end
                else
                begin
                    a_next = ln_reg;
                end
                state_next = S_Q_CMP;
            end
            S_Q_CMP:
            begin
                if (a_reg == b_reg)
                begin
                    res_next   = a_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    lo_next    = NODE_ONE;
                    best_next  = '0;
                    state_next = S_BS;
                end
            end
            S_BS:
            begin
                if (lo_reg > NODE_W'(hi_reg))
                begin
                    res_next   = best_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    mid_next   = mid_sum[NODE_W-1:1];
                    ln_next    = a_reg;
                    ls_next    = mid_sum[NODE_W-1:1];
                    li_next    = '0;
                    lret_next  = S_BS_A;
                    state_next = S_L_STEP;
                end
            end
            S_BS_A:
            begin
                pa_next    = ln_reg;
                ln_next    = b_reg;
                ls_next    = mid_reg;
                li_next    = '0;
                lret_next  = S_BS_B;
                state_next = S_L_STEP;
            end
            S_BS_B:
            begin
                if (pa_reg == ln_reg)
                begin
                    best_next = pa_reg;
                    hi_next   = mid_reg - DEPTH_W'(1);
                end
                else
                begin
                    lo_next = NODE_W'(mid_reg) + NODE_ONE;
                end
                state_next = S_BS;
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_anc_next   = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= NODE_ONE;
            out_valid_reg <= 1'b0;
            lvl_reg       <= '0;
            li_reg        <= '0;
            lret_reg      <= S_IDLE;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            lvl_reg       <= lvl_next;
            li_reg        <= li_next;
            lret_reg      <= lret_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg    <= node_next;
        x_reg       <= x_next;
        d_reg       <= d_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        da_reg      <= da_next;
        side_reg    <= side_next;
        ln_reg      <= ln_next;
        ls_reg      <= ls_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        pa_reg      <= pa_next;
        best_reg    <= best_next;
        res_reg     <= res_next;
        out_anc_reg <= out_anc_next;
    end

    lcabl_ram #(
        .WIDTH(NODE_W),
        .DEPTH(TBL_DEPTH)
    ) u_table (
        .clk  (clk),
        .we   (t_we),
        .waddr(t_waddr),
        .wdata(t_wdata),
        .raddr(t_raddr),
        .rdata(t_rdata)
    );

    lcabl_ram #(
        .WIDTH(DEPTH_W),
        .DEPTH(DEP_DEPTH)
    ) u_depth (
        .clk  (clk),
        .we   (dp_we),
        .waddr(dp_waddr),
        .wdata(dp_wdata),
        .raddr(dp_raddr),
        .rdata(dp_rdata)
    );

    a_lift_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_L_STEP || state_reg == S_L_WAIT) |-> !t_we)
        else $error("table written during lift");

    a_lift_bound: assert property (@(posedge clk) disable iff (!rst_n)
        li_reg <= LVL_END)
        else $error("lift level out of range");

    a_build_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BD_CHK && lvl_reg == '0 && node_reg == cnt) |=> state_reg == S_IDLE)
        else $error("build did not finish after last node");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && !m_axis_tready) |=> state_reg == S_OUT)
        else $error("result dropped while output stalled");

endmodule

`default_nettype wire
